>>> src/hsv2rgb_pkg.sv
// Shared types, constants and helpers for the HSV to RGB converter.
package hsv2rgb_pkg;

    localparam int HUE_BITS = 16;
    localparam int HUE_W    = 16;
    localparam int CH_W     = 8;
    localparam int HUE6_W   = HUE_BITS + 3;
    localparam int DEN_W    = HUE_BITS + CH_W;
    localparam int TURN_W   = HUE_BITS + 1;
    localparam int PROD_W   = DEN_W + CH_W;
    localparam int SCALED_W = 2 * CH_W;

    localparam logic [CH_W-1:0]   FULL_SCALE = CH_W'(255);
    localparam logic [DEN_W-1:0]  HUE_DEN    = {FULL_SCALE, {HUE_BITS{1'b0}}};
    localparam logic [TURN_W-1:0] HUE_TURN   = {1'b1, {HUE_BITS{1'b0}}};

    typedef enum logic [2:0] {
        SEC_RED_YELLOW,
        SEC_YELLOW_GREEN,
        SEC_GREEN_CYAN,
        SEC_CYAN_BLUE,
        SEC_BLUE_MAGENTA,
        SEC_MAGENTA_RED
    } sector_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

    // floor(y / 255), exact for y up to 255 * 255
    function automatic logic [CH_W-1:0] div255(input logic [SCALED_W-1:0] y);
        logic [SCALED_W:0] sum;
        begin
            sum = {1'b0, y} + {{(CH_W + 1){1'b0}}, y[SCALED_W-1:CH_W]}
                + {{SCALED_W{1'b0}}, 1'b1};
            div255 = sum[SCALED_W-1:CH_W];
        end
    endfunction

endpackage

>>> src/hsv_to_rgb_converter.sv
// Top level of the HSV to RGB converter: a five-stage streaming pipeline.
//
// Input beats arrive on the s_ channel: hue as a fraction of a full turn,
// saturation and brightness as x/255. Each input beat yields one output beat
// on the m_ channel carrying 8-bit red, green and blue, truncated.
//
// Throughput is one beat per cycle while m_tready is high. The stages are:
// hue times six, the p/q/t numerators (a 16x8 and a 17x8 product), the
// products by brightness (24x8 for q and t, 8x8 for p), the divide by 255
// (shift-add reciprocal), and the sector mux into the output register.
//
// Each stage holds its own valid bit and advances when the next stage is
// empty or advancing, so bubbles collapse and s_tready stays high while any
// stage is free. When the receiver holds m_tready low the output beat is
// held and stages fill up behind it; nothing is dropped or repeated.
//
// Reset clears all valid bits; the pipeline comes up empty and ready.
module hsv_to_rgb_converter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // hue[15:0], saturation[23:16], brightness[31:24]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // red[7:0], green[15:8], blue[23:16]
);

    localparam int HB  = hsv2rgb_pkg::HUE_BITS;
    localparam int CW  = hsv2rgb_pkg::CH_W;
    localparam int H6W = hsv2rgb_pkg::HUE6_W;
    localparam int DW  = hsv2rgb_pkg::DEN_W;
    localparam int TW  = hsv2rgb_pkg::TURN_W;
    localparam int PW  = hsv2rgb_pkg::PROD_W;
    localparam int SW  = hsv2rgb_pkg::SCALED_W;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    logic ld1, ld2, ld3, ld4, ld5;

    assign rdy5 = !v5_reg || m_tready;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign ld1 = s_tvalid && rdy1;
    assign ld2 = v1_reg && rdy2;
    assign ld3 = v2_reg && rdy3;
    assign ld4 = v3_reg && rdy4;
    assign ld5 = v4_reg && rdy5;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // stage 1: hue times six
    logic [HB-1:0]  hue_in;
    logic [H6W-1:0] h6_next, h6_reg;
    logic [CW-1:0]  sat1_reg, val1_reg;

    assign hue_in  = HB'(s_tdata[hsv2rgb_pkg::HUE_W-1:0]);
    assign h6_next = ({3'b000, hue_in} << 2) + ({3'b000, hue_in} << 1);

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            h6_reg   <= h6_next;
            sat1_reg <= s_tdata[23:16];
            val1_reg <= s_tdata[31:24];
        end
    end

    // stage 2: numerators of p, q and t
    logic [HB-1:0]   frac;
    logic [TW-1:0]   rest;
    logic [DW-1:0]   fs;
    logic [DW:0]     rs;
    logic [DW-1:0]   qn_next, tn_next, qn_reg, tn_reg;
    logic [DW:0]     tn_wide;
    logic [CW-1:0]   pn_next, pn_reg, val2_reg;
    logic [2:0]      sec2_reg;

    assign frac    = h6_reg[HB-1:0];
    assign rest    = hsv2rgb_pkg::HUE_TURN - {1'b0, frac};
    assign fs      = frac * sat1_reg;
    assign rs      = rest * sat1_reg;
    assign qn_next = hsv2rgb_pkg::HUE_DEN - fs;
    assign tn_wide = {1'b0, hsv2rgb_pkg::HUE_DEN} - rs;
    assign tn_next = tn_wide[DW-1:0];
    assign pn_next = hsv2rgb_pkg::FULL_SCALE - sat1_reg;

    always_ff @(posedge clk)
    begin
        if (ld2)
        begin
            qn_reg   <= qn_next;
            tn_reg   <= tn_next;
            pn_reg   <= pn_next;
            val2_reg <= val1_reg;
            sec2_reg <= h6_reg[H6W-1:HB];
        end
    end

    // stage 3: scale by brightness, drop the hue fraction bits
    logic [PW-1:0] qx, tx;
    logic [SW-1:0] px_next, qx_next, tx_next;
    logic [SW-1:0] px_reg, qx_reg, tx_reg;
    logic [CW-1:0] val3_reg;
    logic [2:0]    sec3_reg;

    assign qx      = val2_reg * qn_reg;
    assign tx      = val2_reg * tn_reg;
    assign px_next = val2_reg * pn_reg;
    assign qx_next = qx[PW-1:HB];
    assign tx_next = tx[PW-1:HB];

    always_ff @(posedge clk)
    begin
        if (ld3)
        begin
            px_reg   <= px_next;
            qx_reg   <= qx_next;
            tx_reg   <= tx_next;
            val3_reg <= val2_reg;
            sec3_reg <= sec2_reg;
        end
    end

    // stage 4: divide by full scale
    logic [CW-1:0] p4_reg, q4_reg, t4_reg, val4_reg;
    logic [2:0]    sec4_reg;

    always_ff @(posedge clk)
    begin
        if (ld4)
        begin
            p4_reg   <= hsv2rgb_pkg::div255(px_reg);
            q4_reg   <= hsv2rgb_pkg::div255(qx_reg);
            t4_reg   <= hsv2rgb_pkg::div255(tx_reg);
            val4_reg <= val3_reg;
            sec4_reg <= sec3_reg;
        end
    end

    // stage 5: sector mux into the output register
    hsv2rgb_pkg::rgb_t rgb_next, rgb_reg;

    always_comb
    begin
        case (hsv2rgb_pkg::sector_t'(sec4_reg))
            hsv2rgb_pkg::SEC_RED_YELLOW:   rgb_next = '{val4_reg, t4_reg, p4_reg};
            hsv2rgb_pkg::SEC_YELLOW_GREEN: rgb_next = '{q4_reg, val4_reg, p4_reg};
            hsv2rgb_pkg::SEC_GREEN_CYAN:   rgb_next = '{p4_reg, val4_reg, t4_reg};
            hsv2rgb_pkg::SEC_CYAN_BLUE:    rgb_next = '{p4_reg, q4_reg, val4_reg};
            hsv2rgb_pkg::SEC_BLUE_MAGENTA: rgb_next = '{t4_reg, p4_reg, val4_reg};
            default:                       rgb_next = '{val4_reg, p4_reg, q4_reg};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ld5)
        begin
            rgb_reg <= rgb_next;
        end
    end

    assign s_tready = rdy1;
    assign m_tvalid = v5_reg;
    assign m_tdata  = {rgb_reg.blue, rgb_reg.green, rgb_reg.red};

endmodule
